// ----- rtl/vn_pkg.sv -----
// Package for the 2D vector normalizer: default widths and derived sizes.
// No dependencies; used by vn_front, vn_step, vector2_normalize and the testbench.
package vn_pkg;

    // Default component width of the input vector (two's complement)
    localparam int COMPONENT_BITS_DEF = 16;
    // Default fraction bits of the unit-vector output
    localparam int FRACTION_BITS_DEF  = 14;

    // Width of the signed residual and cross-term registers of the root search.
    // Covers sumsq * (2n+1)^2 for n below 2^(frac+1), plus sign.
    function automatic int residual_width(input int comp_bits, input int frac_bits);
        residual_width = 2 * comp_bits + 2 * frac_bits + 5;
    endfunction

endpackage

// ----- rtl/vn_if.sv -----
// Channel interfaces of the 2D vector normalizer: vector in, unit vector out.
// Valid/ready handshake; no dependencies.
interface vn_in_if #(
    parameter int CB = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] x_component;
    logic signed [CB-1:0] y_component;

    modport source (output valid, output x_component, output y_component, input ready);
    modport sink   (input valid, input x_component, input y_component, output ready);
endinterface

interface vn_out_if #(
    parameter int OB = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [OB-1:0] unit_x;
    logic signed [OB-1:0] unit_y;
    logic                 was_zero;

    modport source (output valid, output unit_x, output unit_y, output was_zero, input ready);
    modport sink   (input valid, input unit_x, input unit_y, input was_zero, output ready);
endinterface

// ----- rtl/vn_front.sv -----
// Front end of the normalizer: magnitudes, squares, sum of squares and the
// initial residuals of the root search, three register stages. Uses vn_pkg.
module vn_front #(
    parameter int CB = vn_pkg::COMPONENT_BITS_DEF,
    parameter int F  = vn_pkg::FRACTION_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [CB-1:0]                         x_in,
    input  logic signed [CB-1:0]                         y_in,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [2*CB-1:0]                              sumsq,
    output logic [vn_pkg::residual_width(CB, F)-1:0]     rx,
    output logic [vn_pkg::residual_width(CB, F)-1:0]     ry,
    output logic [vn_pkg::residual_width(CB, F)-1:0]     q_init,
    output logic                                         neg_x,
    output logic                                         neg_y,
    output logic                                         zero
);
    localparam int RW = vn_pkg::residual_width(CB, F);
    localparam int SW = 2 * CB;
    localparam int TSH = 2 * F + 2;

    // Stage A: sign and magnitude
    logic          a_valid_reg, a_valid_next;
    logic          a_ready;
    logic [CB-1:0] a_mx_reg, a_my_reg;
    logic          a_nx_reg, a_ny_reg, a_zero_reg;
    logic [CB-1:0] x_u, y_u;

    // Stage B: squares
    logic          b_valid_reg, b_valid_next;
    logic          b_ready;
    logic [SW-1:0] b_sqx_reg, b_sqy_reg;
    logic          b_nx_reg, b_ny_reg, b_zero_reg;

    // Stage C: sum of squares and initial residuals
    logic          c_valid_reg, c_valid_next;
    logic          c_ready;
    logic [SW-1:0] c_s_reg;
    logic [RW-1:0] c_rx_reg, c_ry_reg, c_q_reg;
    logic          c_nx_reg, c_ny_reg, c_zero_reg;
    logic [RW-1:0] sum_w;

    assign x_u = x_in;
    assign y_u = y_in;

    // A stage takes a new item when it is empty or its item moves on
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid    : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Stage A payload: full magnitude, the most negative value included
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_mx_reg   <= x_u[CB-1] ? (~x_u) + CB'(1) : x_u;
            a_my_reg   <= y_u[CB-1] ? (~y_u) + CB'(1) : y_u;
            a_nx_reg   <= x_u[CB-1];
            a_ny_reg   <= y_u[CB-1];
            a_zero_reg <= (x_u == '0) && (y_u == '0);
        end
    end

    // Stage B payload: squares
    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_sqx_reg  <= SW'(a_mx_reg) * SW'(a_mx_reg);
            b_sqy_reg  <= SW'(a_my_reg) * SW'(a_my_reg);
            b_nx_reg   <= a_nx_reg;
            b_ny_reg   <= a_ny_reg;
            b_zero_reg <= a_zero_reg;
        end
    end

    // Residual start value: mag^2 * 2^(2F+2) - sumsq, cross term -sumsq
    assign sum_w = RW'(b_sqx_reg) + RW'(b_sqy_reg);

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_s_reg    <= b_sqx_reg + b_sqy_reg;
            c_rx_reg   <= (RW'(b_sqx_reg) << TSH) - RW'(b_sqx_reg) - RW'(b_sqy_reg);
            c_ry_reg   <= (RW'(b_sqy_reg) << TSH) - RW'(b_sqx_reg) - RW'(b_sqy_reg);
            c_q_reg    <= RW'(0) - sum_w;
            c_nx_reg   <= b_nx_reg;
            c_ny_reg   <= b_ny_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign sumsq     = c_s_reg;
    assign rx        = c_rx_reg;
    assign ry        = c_ry_reg;
    assign q_init    = c_q_reg;
    assign neg_x     = c_nx_reg;
    assign neg_y     = c_ny_reg;
    assign zero      = c_zero_reg;

endmodule

// ----- rtl/vn_step.sv -----
// One bit of the rounded-ratio search for both lanes, one register stage.
// Keeps residual r = T - S*(2n-1)^2 and cross term q = S*(2n-1). Uses vn_pkg.
module vn_step #(
    parameter int CB  = vn_pkg::COMPONENT_BITS_DEF,
    parameter int F   = vn_pkg::FRACTION_BITS_DEF,
    parameter int BIT = 0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [2*CB-1:0]                          s_in,
    input  logic [vn_pkg::residual_width(CB, F)-1:0] rx_in,
    input  logic [vn_pkg::residual_width(CB, F)-1:0] ry_in,
    input  logic [vn_pkg::residual_width(CB, F)-1:0] qx_in,
    input  logic [vn_pkg::residual_width(CB, F)-1:0] qy_in,
    input  logic [F:0]                               nx_in,
    input  logic [F:0]                               ny_in,
    input  logic                                     negx_in,
    input  logic                                     negy_in,
    input  logic                                     zero_in,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [2*CB-1:0]                          s_out,
    output logic [vn_pkg::residual_width(CB, F)-1:0] rx_out,
    output logic [vn_pkg::residual_width(CB, F)-1:0] ry_out,
    output logic [vn_pkg::residual_width(CB, F)-1:0] qx_out,
    output logic [vn_pkg::residual_width(CB, F)-1:0] qy_out,
    output logic [F:0]                               nx_out,
    output logic [F:0]                               ny_out,
    output logic                                     negx_out,
    output logic                                     negy_out,
    output logic                                     zero_out
);
    localparam int RW = vn_pkg::residual_width(CB, F);
    localparam int NB = F + 1;

    logic          valid_reg, valid_next;
    logic [2*CB-1:0] s_reg;
    logic [RW-1:0] rx_reg, ry_reg, qx_reg, qy_reg;
    logic [NB-1:0] nx_reg, ny_reg;
    logic          negx_reg, negy_reg, zero_reg;

    logic [RW-1:0] s_w, s_sq_term, s_q_term;
    logic [RW-1:0] cand_x, cand_y;
    logic          take_x, take_y;
    logic [NB-1:0] bit_mask;

    // Trial of n | 2^BIT: (2m-1)^2 = (2n-1)^2 + 2^(BIT+2)(2n-1) + 2^(2BIT+2)
    assign s_w       = RW'(s_in);
    assign s_sq_term = s_w << (2 * BIT + 2);
    assign s_q_term  = s_w << (BIT + 1);
    assign bit_mask  = NB'(1) << BIT;

    assign cand_x = rx_in - (qx_in << (BIT + 2)) - s_sq_term;
    assign cand_y = ry_in - (qy_in << (BIT + 2)) - s_sq_term;
    assign take_x = !cand_x[RW-1];
    assign take_y = !cand_y[RW-1];

    // Handshake
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: keep the bit where the residual stays non-negative
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s_reg    <= s_in;
            rx_reg   <= take_x ? cand_x : rx_in;
            ry_reg   <= take_y ? cand_y : ry_in;
            qx_reg   <= take_x ? qx_in + s_q_term : qx_in;
            qy_reg   <= take_y ? qy_in + s_q_term : qy_in;
            nx_reg   <= take_x ? (nx_in | bit_mask) : nx_in;
            ny_reg   <= take_y ? (ny_in | bit_mask) : ny_in;
            negx_reg <= negx_in;
            negy_reg <= negy_in;
            zero_reg <= zero_in;
        end
    end

    assign out_valid = valid_reg;
    assign s_out     = s_reg;
    assign rx_out    = rx_reg;
    assign ry_out    = ry_reg;
    assign qx_out    = qx_reg;
    assign qy_out    = qy_reg;
    assign nx_out    = nx_reg;
    assign ny_out    = ny_reg;
    assign negx_out  = negx_reg;
    assign negy_out  = negy_reg;
    assign zero_out  = zero_reg;

endmodule

// ----- rtl/vector2_normalize.sv -----
// Top level of the 2D vector normalizer: front end, bit-search stages, output register.
// Depends on vn_pkg, vn_if (vn_in_if, vn_out_if), vn_front and vn_step.
//
// Usage:
//   vec_in carries a vector (x_component, y_component) of signed
//   COMPONENT_BITS-bit integers. unit_out returns the unit vector in signed
//   fixed point with FRACTION_BITS fraction bits (FRACTION_BITS+2 bits wide),
//   rounded to nearest with ties away from zero, and was_zero for (0,0),
//   which gives (0,0). An item moves on at each edge where valid and ready
//   are both high. One result per item, in order.
//   Stages from acceptance to unit_out.valid: three front stages (magnitude,
//   squares, sum and start residual), one stage per result bit and one
//   output register. Throughput: one item per cycle while unit_out.ready
//   stays high; the root search resolves one result bit per stage, with a
//   compare over a residual of 2*COMPONENT_BITS + 2*FRACTION_BITS + 5 bits.
//   Reset clears all valid bits; the pipeline starts empty with no warm-up.
//   When unit_out.ready is low, a stage holds only while the stage after it
//   is full, so empty slots close up and vec_in.ready drops only once every
//   stage holds an item. Nothing is lost or repeated under stalls.
module vector2_normalize #(
    parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vn_in_if.sink     vec_in,
    vn_out_if.source  unit_out
);
    localparam int CB    = COMPONENT_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int RW    = vn_pkg::residual_width(CB, F);
    localparam int NSTEP = F + 1;
    localparam int OB    = F + 2;

    // Inter-stage wiring; index k feeds step k, index NSTEP feeds the output
    logic            vld_p  [NSTEP+1];
    logic            rdy_p  [NSTEP+1];
    logic [2*CB-1:0] s_p    [NSTEP+1];
    logic [RW-1:0]   rx_p   [NSTEP+1];
    logic [RW-1:0]   ry_p   [NSTEP+1];
    logic [RW-1:0]   qx_p   [NSTEP+1];
    logic [RW-1:0]   qy_p   [NSTEP+1];
    logic [F:0]      nx_p   [NSTEP+1];
    logic [F:0]      ny_p   [NSTEP+1];
    logic            negx_p [NSTEP+1];
    logic            negy_p [NSTEP+1];
    logic            zero_p [NSTEP+1];
    logic [RW-1:0]   q_init;

    // Output register
    logic          o_valid_reg, o_valid_next;
    logic          o_ready;
    logic [OB-1:0] o_ux_reg, o_uy_reg;
    logic          o_zero_reg;
    logic [OB-1:0] mag_x, mag_y;

    vn_front #(
        .CB (CB),
        .F  (F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec_in.valid),
        .in_ready  (vec_in.ready),
        .x_in      (vec_in.x_component),
        .y_in      (vec_in.y_component),
        .out_valid (vld_p[0]),
        .out_ready (rdy_p[0]),
        .sumsq     (s_p[0]),
        .rx        (rx_p[0]),
        .ry        (ry_p[0]),
        .q_init    (q_init),
        .neg_x     (negx_p[0]),
        .neg_y     (negy_p[0]),
        .zero      (zero_p[0])
    );

    // Search starts at n = 0, where q = S*(2n-1) = -S
    assign qx_p[0] = q_init;
    assign qy_p[0] = q_init;
    assign nx_p[0] = '0;
    assign ny_p[0] = '0;

    // One stage per result bit, most significant first
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        vn_step #(
            .CB  (CB),
            .F   (F),
            .BIT (F - i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld_p[i]),
            .in_ready  (rdy_p[i]),
            .s_in      (s_p[i]),
            .rx_in     (rx_p[i]),
            .ry_in     (ry_p[i]),
            .qx_in     (qx_p[i]),
            .qy_in     (qy_p[i]),
            .nx_in     (nx_p[i]),
            .ny_in     (ny_p[i]),
            .negx_in   (negx_p[i]),
            .negy_in   (negy_p[i]),
            .zero_in   (zero_p[i]),
            .out_valid (vld_p[i+1]),
            .out_ready (rdy_p[i+1]),
            .s_out     (s_p[i+1]),
            .rx_out    (rx_p[i+1]),
            .ry_out    (ry_p[i+1]),
            .qx_out    (qx_p[i+1]),
            .qy_out    (qy_p[i+1]),
            .nx_out    (nx_p[i+1]),
            .ny_out    (ny_p[i+1]),
            .negx_out  (negx_p[i+1]),
            .negy_out  (negy_p[i+1]),
            .zero_out  (zero_p[i+1])
        );
    end

    // Output stage handshake
    assign o_ready        = !o_valid_reg || unit_out.ready;
    assign rdy_p[NSTEP]   = o_ready;
    assign o_valid_next   = o_ready ? vld_p[NSTEP] : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    // Apply sign; zero vector forced to (0,0)
    assign mag_x = OB'(nx_p[NSTEP]);
    assign mag_y = OB'(ny_p[NSTEP]);

    always_ff @(posedge clk)
    begin
        if (o_ready && vld_p[NSTEP])
        begin
            o_ux_reg   <= zero_p[NSTEP] ? '0 : (negx_p[NSTEP] ? OB'(0) - mag_x : mag_x);
            o_uy_reg   <= zero_p[NSTEP] ? '0 : (negy_p[NSTEP] ? OB'(0) - mag_y : mag_y);
            o_zero_reg <= zero_p[NSTEP];
        end
    end

    assign unit_out.valid    = o_valid_reg;
    assign unit_out.unit_x   = o_ux_reg;
    assign unit_out.unit_y   = o_uy_reg;
    assign unit_out.was_zero = o_zero_reg;

    // Residuals and cross terms of the last stage are not needed further
    logic unused_tail;
    assign unused_tail = ^{rx_p[NSTEP], ry_p[NSTEP], qx_p[NSTEP], qy_p[NSTEP], s_p[NSTEP]};

endmodule

// ----- tb/sv/vector2_normalize_tb.sv -----
// Testbench for vector2_normalize: random and corner-case vectors with bursty input
// and random output backpressure; results are checked against an exact integer predictor.
// Depends on vn_pkg, vn_if (vn_in_if, vn_out_if) and the vector2_normalize RTL.
`timescale 1ns / 100ps

module vector2_normalize_tb;

    localparam int CB      = vn_pkg::COMPONENT_BITS_DEF;
    localparam int FB      = vn_pkg::FRACTION_BITS_DEF;
    localparam int OB      = FB + 2;
    localparam int LATENCY = FB + 5;
    localparam int N_RANDOM = 500;

    // Expected unit vectors, oldest first, with the vector that produced each
    class unit_vector_scoreboard;
        typedef struct {
            logic signed [CB-1:0] x;
            logic signed [CB-1:0] y;
            logic signed [OB-1:0] unit_x;
            logic signed [OB-1:0] unit_y;
            logic                 was_zero;
        } unit_vector_t;

        unit_vector_t expected_units[$];
        int mismatches      = 0;
        int vectors_noted   = 0;
        int results_checked = 0;
        int zero_vectors    = 0;

        // Largest n with (2n-1)^2 * sumsq <= (2 * mag * 2^FB)^2, i.e. the
        // ratio mag * 2^FB / sqrt(sumsq) rounded to nearest, ties away from zero.
        function bit [OB-1:0] rounded_ratio(bit [CB:0] mag, bit [2*CB-1:0] sumsq);
            bit [127:0]  target;
            bit [127:0]  lhs;
            bit [OB-1:0] n;
            bit [OB-1:0] trial;
            bit [OB:0]   odd;
            target = 128'(mag) << (FB + 1);
            target = target * target;
            n = '0;
            for (int b = FB; b >= 0; b--)
            begin
                trial = n | (OB'(1) << b);
                odd   = {trial, 1'b0} - 1'b1;
                lhs   = 128'(odd) * 128'(odd) * 128'(sumsq);
                if (lhs <= target)
                    n = trial;
            end
            return n;
        endfunction

        function void note_vector(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
            unit_vector_t exp_unit;
            bit [CB:0]     mag_x;
            bit [CB:0]     mag_y;
            bit [2*CB-1:0] sumsq;
            bit [OB-1:0]   rx;
            bit [OB-1:0]   ry;
            // full magnitude, so the most negative value is not lost
            mag_x = x[CB-1] ? (CB+1)'(-$signed({x[CB-1], x})) : (CB+1)'(x);
            mag_y = y[CB-1] ? (CB+1)'(-$signed({y[CB-1], y})) : (CB+1)'(y);
            exp_unit.x = x;
            exp_unit.y = y;
            if (mag_x == 0 && mag_y == 0)
            begin
                exp_unit.unit_x   = '0;
                exp_unit.unit_y   = '0;
                exp_unit.was_zero = 1'b1;
                zero_vectors++;
            end
            else
            begin
                sumsq = (2*CB)'(mag_x * mag_x) + (2*CB)'(mag_y * mag_y);
                rx = rounded_ratio(mag_x, sumsq);
                ry = rounded_ratio(mag_y, sumsq);
                exp_unit.unit_x   = x[CB-1] ? -rx : rx;
                exp_unit.unit_y   = y[CB-1] ? -ry : ry;
                exp_unit.was_zero = 1'b0;
            end
            expected_units.push_back(exp_unit);
            vectors_noted++;
        endfunction

        function void check_result(logic signed [OB-1:0] unit_x,
                                   logic signed [OB-1:0] unit_y, logic was_zero);
            unit_vector_t exp_unit;
            results_checked++;
            if (expected_units.size() == 0)
            begin
                $display("%0t ERROR unexpected result: expected none, actual (%0d, %0d, zero=%0b)",
                         $realtime, unit_x, unit_y, was_zero);
                mismatches++;
                return;
            end
            exp_unit = expected_units.pop_front();
            if (unit_x !== exp_unit.unit_x)
            begin
                $display("%0t ERROR unit_x for (%0d, %0d): expected %0d actual %0d",
                         $realtime, exp_unit.x, exp_unit.y, exp_unit.unit_x, unit_x);
                mismatches++;
            end
            if (unit_y !== exp_unit.unit_y)
            begin
                $display("%0t ERROR unit_y for (%0d, %0d): expected %0d actual %0d",
                         $realtime, exp_unit.x, exp_unit.y, exp_unit.unit_y, unit_y);
                mismatches++;
            end
            if (was_zero !== exp_unit.was_zero)
            begin
                $display("%0t ERROR was_zero for (%0d, %0d): expected %0b actual %0b",
                         $realtime, exp_unit.x, exp_unit.y, exp_unit.was_zero, was_zero);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_units.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    vn_in_if  #(.CB(CB)) vec_in_ch ();
    vn_out_if #(.OB(OB)) unit_out_ch ();

    vector2_normalize #(
        .COMPONENT_BITS (CB),
        .FRACTION_BITS  (FB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vec_in   (vec_in_ch),
        .unit_out (unit_out_ch)
    );

    unit_vector_scoreboard sb = new();

    int burst_left      = 0;
    int backpressure_cy = 0;
    int stall_cy        = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Random component: full range, small values, extremes, zero, powers of two
    function automatic logic signed [CB-1:0] random_component();
        logic signed [CB-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = CB'($urandom);
            4:          v = CB'($signed($urandom_range(0, 32)) - 16);
            5:
            begin
                case ($urandom_range(0, 5))
                    0:       v = {1'b1, {(CB-1){1'b0}}};
                    1:       v = {1'b0, {(CB-1){1'b1}}};
                    2:       v = {1'b1, {(CB-2){1'b0}}, 1'b1};
                    3:       v = '1;
                    4:       v = CB'(1);
                    default: v = '0;
                endcase
            end
            6:          v = '0;
            7:
            begin
                v = CB'(1) << $urandom_range(0, CB-1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default:    v = CB'($urandom_range(0, 1023)) - CB'(512);
        endcase
        return v;
    endfunction

    // Offer one vector, called at a falling edge; returns at the falling edge
    // after the item is taken. Gaps between bursts carry junk data with valid low.
    task automatic send_vector(logic signed [CB-1:0] x, logic signed [CB-1:0] y);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            if (gap > 0)
            begin
                vec_in_ch.valid       <= 1'b0;
                vec_in_ch.x_component <= CB'($urandom);
                vec_in_ch.y_component <= CB'($urandom);
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        vec_in_ch.valid       <= 1'b1;
        vec_in_ch.x_component <= x;
        vec_in_ch.y_component <= y;
        do
            @(posedge clk);
        while (!vec_in_ch.ready);
        sb.note_vector(x, y);
        burst_left--;
        @(negedge clk);
    endtask

    // Stimulus: reset, corner vectors, then random vectors
    initial
    begin
        logic signed [CB-1:0] corner_x[$];
        logic signed [CB-1:0] corner_y[$];
        logic signed [CB-1:0] rx;
        logic signed [CB-1:0] ry;
        corner_x = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, 0,
                     1, -1, 3, -3, 1, 32767, 21845, -21846, -1, 2, -32767, 16384};
        corner_y = '{0, 0, 0, -32768, 32767, -32768, 32767, 32767, -32768, 0, -1,
                     1, 1, 4, -4, -32768, -1, -21846, 21845, -1, -3, 1, -16384};
        rst_n                 = 1'b0;
        vec_in_ch.valid       = 1'b0;
        vec_in_ch.x_component = '0;
        vec_in_ch.y_component = '0;
        unit_out_ch.ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_x[i])
            send_vector(corner_x[i], corner_y[i]);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                rx = '0;
                ry = '0;
            end
            else
            begin
                rx = random_component();
                ry = random_component();
            end
            send_vector(rx, ry);
        end
        vec_in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("Checked %0d results from %0d vectors (%0d zero vectors), %0d mismatches.",
                 sb.results_checked, sb.vectors_noted, sb.zero_vectors, sb.mismatches);
        $display("Output stalled on %0d cycles; input held off on %0d cycles.",
                 stall_cy, backpressure_cy);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Output ready: modes change now and then; long stalls fill the pipeline
    initial
    begin
        int mode_left;
        int mode;
        int stall_left;
        bit [7:0] ready_mask;
        mode_left  = 0;
        mode       = 0;
        stall_left = 0;
        ready_mask = 8'hff;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode       = $urandom_range(0, 4);
                mode_left  = $urandom_range(30, 200);
                ready_mask = 8'($urandom) | 8'h01;
                stall_left = $urandom_range(LATENCY + 5, LATENCY + 25);
            end
            mode_left--;
            case (mode)
                0: unit_out_ch.ready <= 1'b1;
                1: unit_out_ch.ready <= 1'($urandom_range(0, 1));
                2: unit_out_ch.ready <= ($urandom_range(0, 3) == 0);
                3: unit_out_ch.ready <= ready_mask[mode_left % 8];
                default:
                begin
                    // one long stall, then free running
                    unit_out_ch.ready <= (stall_left == 0);
                    if (stall_left > 0)
                        stall_left--;
                end
            endcase
        end
    end

    // Result check and handshake statistics
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (unit_out_ch.valid && unit_out_ch.ready)
                sb.check_result(unit_out_ch.unit_x, unit_out_ch.unit_y, unit_out_ch.was_zero);
            if (unit_out_ch.valid && !unit_out_ch.ready)
                stall_cy++;
            if (vec_in_ch.valid && !vec_in_ch.ready)
                backpressure_cy++;
        end
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Run limit reached with %0d results outstanding.", sb.pending());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- vector2_normalize.f -----
rtl/vn_pkg.sv
rtl/vn_if.sv
rtl/vn_front.sv
rtl/vn_step.sv
rtl/vector2_normalize.sv
tb/sv/vector2_normalize_tb.sv
